// File: rtl/csb_pkg.sv
// Shared types and constants for the cursor sequence buffer.
package csb_pkg;

   localparam int CAPACITY_DEFAULT   = 64;
   localparam int WORD_WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      CMD_START   = 3'd0,
      CMD_ADVANCE = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_ATTACH  = 3'd3,
      CMD_REMOVE  = 3'd4,
      CMD_READ    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_NO_CURRENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_ADVANCE,
      OP_REWIND,
      OP_PUSH,
      OP_ATTACH,
      OP_LEFT_UP,
      OP_POP
   } cell_op_type;

   typedef enum logic [0:0] {
      S_IDLE,
      S_REWIND
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic        has_current;
      logic [31:0] current_value;
      logic [6:0]  item_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic       has_current;
      logic [6:0] item_count;
      logic [1:0] status;
   } rsp_meta_type;

endpackage

// File: rtl/csb_cell.sv
// One cell of the chain: one word of the left stack and one of the right stack.
module csb_cell #(
   parameter int WORD_WIDTH = csb_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  csb_pkg::cell_op_type  op,
   input  logic [WORD_WIDTH-1:0] below_left,
   input  logic [WORD_WIDTH-1:0] below_right,
   input  logic [WORD_WIDTH-1:0] above_left,
   input  logic [WORD_WIDTH-1:0] above_right,
   output logic [WORD_WIDTH-1:0] left_word,
   output logic [WORD_WIDTH-1:0] right_word
);
   import csb_pkg::*;

   logic [WORD_WIDTH-1:0] left_word_ff;
   logic [WORD_WIDTH-1:0] left_word_in;
   logic [WORD_WIDTH-1:0] right_word_ff;
   logic [WORD_WIDTH-1:0] right_word_in;

   always_comb begin
      left_word_in  = left_word_ff;
      right_word_in = right_word_ff;
      case (op)
         OP_ADVANCE: begin
            left_word_in  = below_left;
            right_word_in = above_right;
         end
         OP_REWIND: begin
            left_word_in  = above_left;
            right_word_in = below_right;
         end
         OP_PUSH: begin
            right_word_in = below_right;
         end
         OP_ATTACH: begin
            left_word_in  = below_left;
            right_word_in = below_right;
         end
         OP_LEFT_UP: begin
            left_word_in  = below_left;
         end
         OP_POP: begin
            right_word_in = above_right;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      left_word_ff  <= left_word_in;
      right_word_ff <= right_word_in;
   end

   assign left_word  = left_word_ff;
   assign right_word = right_word_ff;

endmodule

// File: rtl/csb_ctrl.sv
// Control: stack counts, command decode, rewind sequencer and response register.
module csb_ctrl #(
   parameter int CAPACITY = csb_pkg::CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  csb_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output csb_pkg::rsp_meta_type rsp_meta,
   output csb_pkg::cell_op_type  cell_op,
   output logic [31:0]           push_value
);
   import csb_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0] left_count_ff, left_count_in;
   logic [CNT_W-1:0] right_count_ff, right_count_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [31:0]      value_ff, value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_meta_type     meta_ff, meta_in;

   logic [2:0]       act_cmd;
   logic [31:0]      act_value;
   logic [CNT_W:0]   total;
   logic             cur;
   logic             full;
   logic             out_free;
   logic             accept;
   logic             step;
   logic             rewind_needed;
   cell_op_type      op_x;
   logic [CNT_W-1:0] left_x;
   logic [CNT_W-1:0] right_x;
   status_type       status_x;
   logic [CNT_W:0]   total_x;

   assign act_cmd   = (state_ff == S_REWIND) ? cmd_ff : req_data.command;
   assign act_value = (state_ff == S_REWIND) ? value_ff : req_data.entry_value;
   assign total     = (CNT_W + 1)'(left_count_ff) + (CNT_W + 1)'(right_count_ff);
   assign cur       = (right_count_ff != '0);
   assign full      = (total >= (CNT_W + 1)'(CAPACITY));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = (state_ff == S_IDLE) && req_valid && out_free;
   assign step      = accept || (state_ff == S_REWIND);

   // the left stack must be drained into the right one before these run
   assign rewind_needed = (left_count_ff != '0)
      && ((state_ff == S_REWIND) || (act_cmd == CMD_START)
          || ((act_cmd == CMD_INSERT) && !full && !cur));

   always_comb begin
      op_x     = OP_HOLD;
      left_x   = left_count_ff;
      right_x  = right_count_ff;
      status_x = ST_OK;
      case (act_cmd)
         CMD_START: begin
         end
         CMD_ADVANCE: begin
            if (cur) begin
               op_x    = OP_ADVANCE;
               left_x  = left_count_ff + CNT_W'(1);
               right_x = right_count_ff - CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            if (full) begin
               status_x = ST_FULL;
            end else begin
               op_x    = OP_PUSH;
               right_x = right_count_ff + CNT_W'(1);
            end
         end
         CMD_ATTACH: begin
            if (full) begin
               status_x = ST_FULL;
            end else if (cur) begin
               op_x   = OP_ATTACH;
               left_x = left_count_ff + CNT_W'(1);
            end else begin
               op_x    = OP_PUSH;
               right_x = right_count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (!cur) begin
               status_x = ST_NO_CURRENT;
            end else begin
               op_x    = OP_POP;
               right_x = right_count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign total_x = (CNT_W + 1)'(left_x) + (CNT_W + 1)'(right_x);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && rewind_needed) begin
               state_in = S_REWIND;
            end
         end
         S_REWIND: begin
            if (!rewind_needed) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cell_op        = OP_HOLD;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      cmd_in         = cmd_ff;
      value_in       = value_ff;
      meta_in        = meta_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (accept) begin
         cmd_in   = req_data.command;
         value_in = req_data.entry_value;
      end
      if (step) begin
         if (rewind_needed) begin
            cell_op        = OP_REWIND;
            left_count_in  = left_count_ff - CNT_W'(1);
            right_count_in = right_count_ff + CNT_W'(1);
         end else begin
            cell_op             = op_x;
            left_count_in       = left_x;
            right_count_in      = right_x;
            meta_in.has_current = (right_x != '0);
            meta_in.item_count  = 7'(total_x);
            meta_in.status      = status_x;
            rsp_valid_in        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         left_count_ff  <= '0;
         right_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      meta_ff  <= meta_in;
   end

   assign req_stall  = !((state_ff == S_IDLE) && out_free);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_meta   = meta_ff;
   assign push_value = act_value;

endmodule

// File: rtl/cursor_sequence_buffer_unit.sv
// Top level of the cursor sequence buffer: control plus the chain of cells.
//
//   port group  direction  carries
//   req_        in         command and entry value
//   rsp_        out        current item, its validity, count and status
//
// Start, and insert with room but no current item, first drain every item before
// the cursor: the left stack drains into the right stack one cell a cycle; other
// commands need no drain.
// Reset clears the counts, the sequencer and the response valid; the cells
// are not cleared and need no clearing pass.
// A new item is taken in the cycle the previous response leaves.
module cursor_sequence_buffer_unit #(
   parameter int CAPACITY   = csb_pkg::CAPACITY_DEFAULT,
   parameter int WORD_WIDTH = csb_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  csb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output csb_pkg::rsp_type rsp_data
);
   import csb_pkg::*;

   cell_op_type           cell_op;
   logic [31:0]           push_value;
   rsp_meta_type          rsp_meta;
   logic [WORD_WIDTH-1:0] left_word  [CAPACITY];
   logic [WORD_WIDTH-1:0] right_word [CAPACITY];
   logic [WORD_WIDTH-1:0] head_right_feed;

   csb_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_meta   (rsp_meta),
      .cell_op    (cell_op),
      .push_value (push_value)
   );

   assign head_right_feed = (cell_op == OP_REWIND) ? left_word[0]
                                                   : WORD_WIDTH'(push_value);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_op_type           op_i;
      logic [WORD_WIDTH-1:0] below_left_i;
      logic [WORD_WIDTH-1:0] below_right_i;
      logic [WORD_WIDTH-1:0] above_left_i;
      logic [WORD_WIDTH-1:0] above_right_i;

      if (i == 0) begin : g_head
         assign op_i          = cell_op;
         assign below_left_i  = right_word[0];
         assign below_right_i = head_right_feed;
      end else begin : g_body
         assign op_i          = (cell_op == OP_ATTACH) ? OP_LEFT_UP : cell_op;
         assign below_left_i  = left_word[i-1];
         assign below_right_i = right_word[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign above_left_i  = left_word[i];
         assign above_right_i = right_word[i];
      end else begin : g_inner
         assign above_left_i  = left_word[i+1];
         assign above_right_i = right_word[i+1];
      end

      csb_cell #(
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock       (clock),
         .op          (op_i),
         .below_left  (below_left_i),
         .below_right (below_right_i),
         .above_left  (above_left_i),
         .above_right (above_right_i),
         .left_word   (left_word[i]),
         .right_word  (right_word[i])
      );
   end

   assign rsp_data.has_current   = rsp_meta.has_current;
   assign rsp_data.current_value = rsp_meta.has_current ? 32'(right_word[0]) : '0;
   assign rsp_data.item_count    = rsp_meta.item_count;
   assign rsp_data.status        = rsp_meta.status;

endmodule

// File: rtl/csb_checker.sv
// Port-level checks for the cursor sequence buffer, bound to the top level.
module csb_checker #(
   parameter int CAPACITY = csb_pkg::CAPACITY_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input csb_pkg::rsp_type rsp_data
);
   import csb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item taken while a response is held");

   a_empty_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_current |-> rsp_data.current_value == '0)
      else $error("value shown without a current item");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.item_count == 7'(CAPACITY))
      else $error("full status with store not full");

   a_remove_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NO_CURRENT |-> !rsp_data.has_current)
      else $error("failed remove left a current item");

endmodule

bind cursor_sequence_buffer_unit csb_checker #(.CAPACITY(CAPACITY)) u_csb_checker (.*);
